// File: hdl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hash.
`timescale 1ns / 1ps

package sha256_pkg;

    typedef logic [31:0] word_t;

    localparam logic [1:0] CMD_DATA    = 2'd0;
    localparam logic [1:0] CMD_FINISH  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [7:0] PAD_MARKER   = 8'h80;
    localparam logic [5:0] LEN_POS      = 6'd56;
    localparam logic [5:0] BLOCK_LAST   = 6'd63;
    localparam logic [5:0] ROUND_LAST   = 6'd63;
    localparam logic [2:0] WORD_LAST    = 3'd7;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       init_hash;
        logic       load_work;
        logic       do_round;
        logic [5:0] round_num;
        logic       do_update;
        logic [2:0] word_sel;
    } core_ctrl_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic word_t choose(input word_t e, input word_t f, input word_t g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic word_t majority(input word_t a, input word_t b, input word_t c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// File: hdl/sha256_msg_if.sv
// Message channel: command and data byte with valid/ready.
`timescale 1ns / 1ps

interface sha256_msg_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink (input valid, input cmd, input data_byte, output ready);
endinterface

// File: hdl/sha256_digest_if.sv
// Digest channel: one digest word per transfer with valid/ready.
`timescale 1ns / 1ps

interface sha256_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

// File: hdl/sha256_byte_stream_hash.sv
// Top level of the SHA-256 byte stream hash: command sequencer, padding and digest output.
//
//   channel  dir  fields                            transfer
//   msg      in   cmd[1:0], data_byte[7:0]           valid & ready
//   digest   out  digest_word[31:0], word_index[2:0], last   valid & ready
//
// Each accepted data byte is shifted into the block buffer; every 64th byte also starts
// a compression (load, 64 rounds, hash update) run by the one-round-per-cycle core.
// Finish shifts in the padding bytes, then compresses each padded block
// (two blocks when more than 55 bytes are pending), then emits eight words.
// A repeated finish emits the eight words at once. msg is ready only when idle.
// Digest words hold while ready is low. Reset loads the initial hash and clears counts.
`timescale 1ns / 1ps

module sha256_byte_stream_hash (
    input  logic                    clk,
    input  logic                    rst_n,
    sha256_msg_if.sink              msg,
    sha256_digest_if.source         digest
);

    sha256_pkg::state_t     state_reg;
    sha256_pkg::state_t     state_next;
    logic [5:0]             count_reg;
    logic [5:0]             count_next;
    logic [63:0]            bits_reg;
    logic [63:0]            bits_next;
    logic [63:0]            len_reg;
    logic [63:0]            len_next;
    logic                   finished_reg;
    logic                   finished_next;
    logic                   pad_reg;
    logic                   pad_next;
    logic                   len_sent_reg;
    logic                   len_sent_next;
    logic [5:0]             round_reg;
    logic [5:0]             round_next;
    logic [2:0]             idx_reg;
    logic [2:0]             idx_next;
    sha256_pkg::core_ctrl_t ctrl;
    sha256_pkg::word_t      core_word;
    logic [63:0]            total_bits;

    assign total_bits = bits_reg + {55'd0, count_reg, 3'b000};

    sha256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .digest_word (core_word)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        bits_next     = bits_reg;
        len_next      = len_reg;
        finished_next = finished_reg;
        pad_next      = pad_reg;
        len_sent_next = len_sent_reg;
        round_next    = round_reg;
        idx_next      = idx_reg;
        ctrl          = '0;
        ctrl.byte_val = msg.data_byte;
        ctrl.round_num = round_reg;
        ctrl.word_sel = idx_reg;
        msg.ready     = 1'b0;
        digest.valid  = 1'b0;

        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                msg.ready = 1'b1;
                if (msg.valid)
                begin
                    case (msg.cmd)
                        sha256_pkg::CMD_DATA:
                        begin
                            if (!finished_reg)
                            begin
                                ctrl.shift_byte = 1'b1;
                                count_next = count_reg + 6'd1;
                                if (count_reg == sha256_pkg::BLOCK_LAST)
                                begin
                                    pad_next   = 1'b0;
                                    state_next = sha256_pkg::ST_LOAD;
                                end
                            end
                        end
                        sha256_pkg::CMD_FINISH:
                        begin
                            idx_next = '0;
                            if (finished_reg)
                            begin
                                state_next = sha256_pkg::ST_EMIT;
                            end
                            else
                            begin
                                len_next      = total_bits;
                                pad_next      = 1'b1;
                                len_sent_next = 1'b0;
                                state_next    = sha256_pkg::ST_PAD_MARK;
                            end
                        end
                        sha256_pkg::CMD_RESTART:
                        begin
                            ctrl.init_hash = 1'b1;
                            count_next     = '0;
                            bits_next      = '0;
                            finished_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            sha256_pkg::ST_PAD_MARK:
            begin
                ctrl.shift_byte = 1'b1;
                ctrl.byte_val   = sha256_pkg::PAD_MARKER;
                count_next      = count_reg + 6'd1;
                if (count_reg == sha256_pkg::BLOCK_LAST)
                begin
                    state_next = sha256_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = sha256_pkg::ST_PAD_ZERO;
                end
            end

            sha256_pkg::ST_PAD_ZERO:
            begin
                if (count_reg == sha256_pkg::LEN_POS)
                begin
                    state_next = sha256_pkg::ST_PAD_LEN;
                end
                else
                begin
                    ctrl.shift_byte = 1'b1;
                    ctrl.byte_val   = '0;
                    count_next      = count_reg + 6'd1;
                    if (count_reg == sha256_pkg::BLOCK_LAST)
                    begin
                        state_next = sha256_pkg::ST_LOAD;
                    end
                end
            end

            sha256_pkg::ST_PAD_LEN:
            begin
                ctrl.shift_byte = 1'b1;
                ctrl.byte_val   = len_reg[63:56];
                len_next        = {len_reg[55:0], 8'd0};
                count_next      = count_reg + 6'd1;
                if (count_reg == sha256_pkg::BLOCK_LAST)
                begin
                    len_sent_next = 1'b1;
                    state_next    = sha256_pkg::ST_LOAD;
                end
            end

            sha256_pkg::ST_LOAD:
            begin
                ctrl.load_work = 1'b1;
                round_next     = '0;
                state_next     = sha256_pkg::ST_ROUND;
            end

            sha256_pkg::ST_ROUND:
            begin
                ctrl.do_round = 1'b1;
                round_next    = round_reg + 6'd1;
                if (round_reg == sha256_pkg::ROUND_LAST)
                begin
                    state_next = sha256_pkg::ST_UPDATE;
                end
            end

            sha256_pkg::ST_UPDATE:
            begin
                ctrl.do_update = 1'b1;
                if (!pad_reg)
                begin
                    bits_next  = bits_reg + sha256_pkg::BLOCK_BITS;
                    state_next = sha256_pkg::ST_IDLE;
                end
                else if (len_sent_reg)
                begin
                    finished_next = 1'b1;
                    pad_next      = 1'b0;
                    len_sent_next = 1'b0;
                    idx_next      = '0;
                    state_next    = sha256_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sha256_pkg::ST_PAD_ZERO;
                end
            end

            sha256_pkg::ST_EMIT:
            begin
                digest.valid = 1'b1;
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == sha256_pkg::WORD_LAST)
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    assign digest.digest_word = core_word;
    assign digest.word_index  = idx_reg;
    assign digest.last        = (idx_reg == sha256_pkg::WORD_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            count_reg    <= '0;
            bits_reg     <= '0;
            finished_reg <= 1'b0;
            pad_reg      <= 1'b0;
            len_sent_reg <= 1'b0;
            round_reg    <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            bits_reg     <= bits_next;
            finished_reg <= finished_next;
            pad_reg      <= pad_next;
            len_sent_reg <= len_sent_next;
            round_reg    <= round_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(digest.valid && msg.ready))
        else $error("message accepted while digest words are pending");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (digest.valid && digest.ready && digest.last) |=> msg.ready)
        else $error("sequencer did not return to idle after the last word");

    a_rounds_on_empty_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha256_pkg::ST_ROUND) |-> (count_reg == '0))
        else $error("compression running with bytes pending");

    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(finished_reg) |-> digest.valid && (digest.word_index == '0))
        else $error("digest not presented when the message finished");

    a_repeat_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (msg.valid && msg.ready && msg.cmd == sha256_pkg::CMD_FINISH && finished_reg)
        |=> digest.valid)
        else $error("repeated finish did not emit the digest");
`endif

endmodule

// File: hdl/sha256_core.sv
// Block buffer, rolling message schedule, round datapath and hash state.
`timescale 1ns / 1ps

module sha256_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha256_pkg::core_ctrl_t ctrl,
    output sha256_pkg::word_t      digest_word
);

    logic [511:0]      blk_reg;
    logic [511:0]      blk_next;
    sha256_pkg::word_t wk_reg [8];
    sha256_pkg::word_t wk_next [8];
    sha256_pkg::word_t hash_reg [8];
    sha256_pkg::word_t hash_next [8];

    sha256_pkg::word_t w0;
    sha256_pkg::word_t w16;
    sha256_pkg::word_t t1;
    sha256_pkg::word_t t2;

    assign w0  = blk_reg[511:480];
    assign w16 = sha256_pkg::small_sigma1(blk_reg[63:32]) + blk_reg[223:192]
               + sha256_pkg::small_sigma0(blk_reg[479:448]) + w0;
    assign t1  = wk_reg[7] + sha256_pkg::big_sigma1(wk_reg[4])
               + sha256_pkg::choose(wk_reg[4], wk_reg[5], wk_reg[6])
               + sha256_pkg::ROUND_K[ctrl.round_num] + w0;
    assign t2  = sha256_pkg::big_sigma0(wk_reg[0])
               + sha256_pkg::majority(wk_reg[0], wk_reg[1], wk_reg[2]);

    always_comb
    begin
        blk_next = blk_reg;
        if (ctrl.shift_byte)
        begin
            blk_next = {blk_reg[503:0], ctrl.byte_val};
        end
        else if (ctrl.do_round)
        begin
            blk_next = {blk_reg[479:0], w16};
        end
    end

    always_comb
    begin
        wk_next = wk_reg;
        if (ctrl.load_work)
        begin
            wk_next = hash_reg;
        end
        else if (ctrl.do_round)
        begin
            for (int i = 7; i > 0; i--)
            begin
                wk_next[i] = wk_reg[i-1];
            end
            wk_next[4] = wk_reg[3] + t1;
            wk_next[0] = t1 + t2;
        end
    end

    always_comb
    begin
        hash_next = hash_reg;
        if (ctrl.init_hash)
        begin
            hash_next = sha256_pkg::INIT_HASH;
        end
        else if (ctrl.do_update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hash_next[i] = hash_reg[i] + wk_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        wk_reg  <= wk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= sha256_pkg::INIT_HASH;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign digest_word = hash_reg[ctrl.word_sel];

endmodule
